FILE: hdl/pfp_pkg.sv
// Package for the plane-from-three-points pipeline.
// Holds fixed widths, saturation limits and stage numbers; depends on nothing.
package pfp_pkg;

    // Fixed widths of the internal datapath and of the result words
    localparam int MANT_W   = 31;          // normalised cross-product magnitude
    localparam int SQ_W     = 2 * MANT_W;  // one square
    localparam int SUMSQ_W  = 64;          // sum of three squares
    localparam int ROOT_W   = 32;          // integer square root
    localparam int RREM_W   = ROOT_W + 3;  // square-root partial remainder
    localparam int NORM_W   = 16;          // normal component word
    localparam int OFFS_W   = 17;          // plane offset word

    // Saturation limits of the result words
    localparam int NORM_POS_MAX = 32767;
    localparam int NORM_NEG_MAX = 32768;
    localparam int OFFS_POS_MAX = 65535;
    localparam int OFFS_NEG_MAX = 65536;

    // Fixed stage numbers; a word is taken in by stage ST_DIFF
    localparam int ST_DIFF = 1;   // edge vectors
    localparam int ST_SHR  = 2;   // common pre-shift of wide vectors
    localparam int ST_MUL  = 3;   // six partial products
    localparam int ST_CRS  = 4;   // cross product
    localparam int ST_MAG  = 5;   // magnitudes, signs, zero test
    localparam int ST_LZ   = 6;   // leading-zero count
    localparam int ST_SHF  = 7;   // block normalisation
    localparam int ST_SQ   = 8;   // squares
    localparam int ST_SUM  = 9;   // sum of squares
    localparam int ST_RT0  = 10;  // first square-root stage
    localparam int ST_DVP  = ST_RT0 + ROOT_W;  // divider set-up
    localparam int ST_DV0  = ST_DVP + 1;       // first divider stage

    // Input-to-result latency in cycles for a given number of normal fraction bits
    function automatic int pfp_latency(input int nfb);
        return ST_DV0 + (nfb + 1) + 3;
    endfunction

endpackage

FILE: hdl/plane_from_three_points.sv
// Plane through three points: fully pipelined cross product, normalisation,
// square root, division and offset. Depends on pfp_pkg.
//
//  channel   | direction | handshake            | fields
//  ----------+-----------+----------------------+-------------------------------------------
//  points    | in        | start (busy is low)  | i_p1_x..i_p3_z, COORD_WIDTH bits, signed
//  plane     | out       | o_valid, one cycle   | o_normal_x/y/z, o_plane_offset, o_degenerate
//
// One word is taken in every cycle; busy is held low.
// Each result's delay after its word is taken in is set by the 32 one-bit square-root
// stages and the NORMAL_FRAC_BITS + 1 one-bit divider stages.
// The synchronous reset clears the stage valid bits only; words in flight are dropped.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module plane_from_three_points
    import pfp_pkg::*;
#(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_p1_x,
    input  logic signed [COORD_WIDTH-1:0] i_p1_y,
    input  logic signed [COORD_WIDTH-1:0] i_p1_z,
    input  logic signed [COORD_WIDTH-1:0] i_p2_x,
    input  logic signed [COORD_WIDTH-1:0] i_p2_y,
    input  logic signed [COORD_WIDTH-1:0] i_p2_z,
    input  logic signed [COORD_WIDTH-1:0] i_p3_x,
    input  logic signed [COORD_WIDTH-1:0] i_p3_y,
    input  logic signed [COORD_WIDTH-1:0] i_p3_z,
    output logic                          o_valid,
    output logic signed [NORM_W-1:0]      o_normal_x,
    output logic signed [NORM_W-1:0]      o_normal_y,
    output logic signed [NORM_W-1:0]      o_normal_z,
    output logic signed [OFFS_W-1:0]      o_plane_offset,
    output logic                          o_degenerate
);

    localparam int CW   = COORD_WIDTH;
    localparam int NFB  = NORMAL_FRAC_BITS;
    localparam int DW   = CW + 1;                        // edge vector component
    localparam int UW   = (DW > 32) ? 32 : DW;           // after pre-shift
    localparam int BLW  = $clog2(DW + 1);
    localparam int PW   = 2 * UW;                        // partial product
    localparam int XW   = PW + 1;                        // cross component
    localparam int MW   = PW;                            // cross magnitude
    localparam int EW   = (MW > MANT_W) ? MW : MANT_W;   // normalisation window
    localparam int LZW  = $clog2(EW + 1);
    localparam int QW   = NFB + 1;                       // quotient bits
    localparam int NW   = ROOT_W + NFB;                  // dividend
    localparam int DRW  = ROOT_W + 1;                    // divider remainder
    localparam int QXW  = (QW > OFFS_W) ? QW : OFFS_W;
    localparam int DPW  = NORM_W + CW;                   // normal times coordinate
    localparam int DTW  = DPW + 2;                       // dot product
    localparam int RXW  = DTW + 1;                       // offset rounding
    localparam int ST_SAT = ST_DV0 + QW;
    localparam int LAT    = pfp_latency(NFB);

    // Stage valid bits
    logic r_vld [1:LAT];

    // Side data carried along the pipeline
    logic signed [CW-1:0]     r_p1  [0:2][ST_DIFF:ST_SAT];
    logic                     r_neg [0:2][ST_MAG:ST_SAT-1];
    logic                     r_deg [ST_MAG:LAT];
    logic [MANT_W-1:0]        r_m   [0:2][ST_SHF:ST_DVP-1];
    logic signed [NORM_W-1:0] r_n   [0:2][ST_SAT:LAT];

    // Front-end registers
    logic signed [DW-1:0] r_u   [0:2];
    logic signed [DW-1:0] r_v   [0:2];
    logic signed [UW-1:0] r_us  [0:2];
    logic signed [UW-1:0] r_vs  [0:2];
    logic signed [PW-1:0] r_pa  [0:2];
    logic signed [PW-1:0] r_pb  [0:2];
    logic signed [XW-1:0] r_c   [0:2];
    logic [MW-1:0]        r_cm  [0:2];
    logic [MW-1:0]        r_cor;
    logic [MW-1:0]        r_lm  [0:2];
    logic [LZW-1:0]       r_lz;
    logic [SQ_W-1:0]      r_sq  [0:2];
    logic [SUMSQ_W-1:0]   r_ss;

    // Square-root and divider registers
    logic [SUMSQ_W-1:0] r_rt_s [0:ROOT_W-2];
    logic [RREM_W-1:0]  r_rt_r [0:ROOT_W-2];
    logic [ROOT_W-1:0]  r_rt_q [0:ROOT_W-1];
    logic [ROOT_W-1:0]  r_pr_len;
    logic [DRW-1:0]     r_pr_rem [0:2];
    logic [QW-1:0]      r_pr_lo  [0:2];
    logic [ROOT_W-1:0]  r_dv_len [0:QW-2];
    logic [DRW-1:0]     r_dv_rem [0:2][0:QW-2];
    logic [QW-1:0]      r_dv_lo  [0:2][0:QW-2];
    logic [QW-1:0]      r_dv_q   [0:2][0:QW-1];

    // Back-end registers
    logic signed [DPW-1:0]    r_dot [0:2];
    logic signed [DTW-1:0]    r_d;
    logic signed [OFFS_W-1:0] r_off;

    // Pre-shift of one edge vector so that every magnitude fits in 31 bits
    function automatic logic [3*UW-1:0] shrink3(input logic signed [DW-1:0] a0,
                                                 input logic signed [DW-1:0] a1,
                                                 input logic signed [DW-1:0] a2);
        logic [DW-1:0]        m0, m1, m2, mor;
        logic [BLW-1:0]       bl, sh;
        logic signed [UW-1:0] s0, s1, s2;
        m0  = a0[DW-1] ? DW'(-a0) : DW'(a0);
        m1  = a1[DW-1] ? DW'(-a1) : DW'(a1);
        m2  = a2[DW-1] ? DW'(-a2) : DW'(a2);
        mor = m0 | m1 | m2;
        bl  = '0;
        for (int k = 0; k < DW; k++) begin
            if (mor[k]) begin
                bl = BLW'(k + 1);
            end
        end
        sh = '0;
        if (int'(bl) > MANT_W) begin
            sh = BLW'(int'(bl) - MANT_W);
        end
        s0 = UW'(m0 >> sh);
        s1 = UW'(m1 >> sh);
        s2 = UW'(m2 >> sh);
        s0 = a0[DW-1] ? -s0 : s0;
        s1 = a1[DW-1] ? -s1 : s1;
        s2 = a2[DW-1] ? -s2 : s2;
        return {s2, s1, s0};
    endfunction

    // Combinational values of the front-end stages
    logic [3*UW-1:0]  n_ush, n_vsh;
    logic [MW-1:0]    n_cm [0:2];
    logic             n_deg;
    logic [EW-1:0]    n_win;
    logic [LZW-1:0]   n_lz;
    logic [EW-1:0]    n_xm [0:2];

    always_comb begin
        n_ush = shrink3(r_u[0], r_u[1], r_u[2]);
        n_vsh = shrink3(r_v[0], r_v[1], r_v[2]);
    end

    // Magnitudes and the all-zero test of the cross product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_cm[i] = r_c[i][XW-1] ? MW'(-r_c[i]) : MW'(r_c[i]);
        end
        n_deg = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
    end

    // Leading zeros of the OR of the magnitudes, placed in the normalisation window
    always_comb begin
        n_win = EW'(r_cor) << (EW - MW);
        n_lz  = '0;
        for (int k = 0; k < EW; k++) begin
            if (n_win[k]) begin
                n_lz = LZW'(EW - 1 - k);
            end
        end
    end

    // Common shift that puts the largest magnitude in [2^30, 2^31)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_xm[i] = (EW'(r_lm[i]) << (EW - MW)) << r_lz;
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[1] <= start;
            for (int k = 2; k <= LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Front end: edge vectors up to the sum of squares
    always_ff @(posedge i_clk) begin
        r_u[0] <= DW'(i_p2_x) - DW'(i_p1_x);
        r_u[1] <= DW'(i_p2_y) - DW'(i_p1_y);
        r_u[2] <= DW'(i_p2_z) - DW'(i_p1_z);
        r_v[0] <= DW'(i_p3_x) - DW'(i_p1_x);
        r_v[1] <= DW'(i_p3_y) - DW'(i_p1_y);
        r_v[2] <= DW'(i_p3_z) - DW'(i_p1_z);
        for (int i = 0; i < 3; i++) begin
            r_us[i] <= n_ush[i*UW +: UW];
            r_vs[i] <= n_vsh[i*UW +: UW];
        end
        r_pa[0] <= PW'(r_us[1]) * PW'(r_vs[2]);
        r_pb[0] <= PW'(r_us[2]) * PW'(r_vs[1]);
        r_pa[1] <= PW'(r_us[2]) * PW'(r_vs[0]);
        r_pb[1] <= PW'(r_us[0]) * PW'(r_vs[2]);
        r_pa[2] <= PW'(r_us[0]) * PW'(r_vs[1]);
        r_pb[2] <= PW'(r_us[1]) * PW'(r_vs[0]);
        for (int i = 0; i < 3; i++) begin
            r_c[i]  <= XW'(r_pa[i]) - XW'(r_pb[i]);
            r_cm[i] <= n_cm[i];
            r_lm[i] <= r_cm[i];
            r_m[i][ST_SHF] <= n_xm[i][EW-1 -: MANT_W];
            for (int k = ST_SHF + 1; k <= ST_DVP - 1; k++) begin
                r_m[i][k] <= r_m[i][k-1];
            end
            r_sq[i] <= SQ_W'(r_m[i][ST_SHF]) * SQ_W'(r_m[i][ST_SHF]);
        end
        r_cor <= n_cm[0] | n_cm[1] | n_cm[2];
        r_lz  <= n_lz;
        r_ss  <= SUMSQ_W'(r_sq[0]) + SUMSQ_W'(r_sq[1]) + SUMSQ_W'(r_sq[2]);
    end

    // Side data shift lines
    always_ff @(posedge i_clk) begin
        r_p1[0][ST_DIFF] <= i_p1_x;
        r_p1[1][ST_DIFF] <= i_p1_y;
        r_p1[2][ST_DIFF] <= i_p1_z;
        r_deg[ST_MAG]    <= n_deg;
        for (int i = 0; i < 3; i++) begin
            r_neg[i][ST_MAG] <= r_c[i][XW-1];
            for (int k = ST_DIFF + 1; k <= ST_SAT; k++) begin
                r_p1[i][k] <= r_p1[i][k-1];
            end
            for (int k = ST_MAG + 1; k <= ST_SAT - 1; k++) begin
                r_neg[i][k] <= r_neg[i][k-1];
            end
        end
        for (int k = ST_MAG + 1; k <= LAT; k++) begin
            r_deg[k] <= r_deg[k-1];
        end
    end

    // Integer square root, one result bit per stage
    for (genvar j = 0; j < ROOT_W; j++) begin : g_root
        logic [SUMSQ_W-1:0] s_in;
        logic [ROOT_W-1:0]  q_in;
        logic [RREM_W-1:0]  rem_in;
        logic [RREM_W-1:0]  n_rem;
        logic [RREM_W-1:0]  trial;
        logic [ROOT_W-1:0]  n_q;

        if (j == 0) begin : g_head
            assign s_in   = r_ss;
            assign q_in   = '0;
            assign rem_in = '0;
        end else begin : g_tail
            assign s_in   = r_rt_s[j-1];
            assign q_in   = r_rt_q[j-1];
            assign rem_in = r_rt_r[j-1];
        end

        always_comb begin
            n_rem = {rem_in[RREM_W-3:0], s_in[SUMSQ_W-1-2*j -: 2]};
            trial = RREM_W'({q_in, 2'b01});
            if (n_rem >= trial) begin
                n_rem = n_rem - trial;
                n_q   = {q_in[ROOT_W-2:0], 1'b1};
            end else begin
                n_q   = {q_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            r_rt_q[j] <= n_q;
        end

        if (j < ROOT_W - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                r_rt_s[j] <= s_in;
                r_rt_r[j] <= n_rem;
            end
        end
    end

    // Divider set-up: dividend is m * 2^NFB plus half the length
    always_ff @(posedge i_clk) begin
        r_pr_len <= r_rt_q[ROOT_W-1];
        for (int i = 0; i < 3; i++) begin
            r_pr_rem[i] <= DRW'(((NW'(r_m[i][ST_DVP-1]) << NFB)
                                 + NW'(r_rt_q[ROOT_W-1] >> 1)) >> (NFB + 1));
            r_pr_lo[i]  <= QW'((NW'(r_m[i][ST_DVP-1]) << NFB) + NW'(r_rt_q[ROOT_W-1] >> 1));
        end
    end

    // Three restoring dividers, one quotient bit per stage
    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [ROOT_W-1:0] len_in;
        if (j == 0) begin : g_hlen
            assign len_in = r_pr_len;
        end else begin : g_tlen
            assign len_in = r_dv_len[j-1];
        end
        if (j < QW - 1) begin : g_klen
            always_ff @(posedge i_clk) begin
                r_dv_len[j] <= len_in;
            end
        end

        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [DRW-1:0] rem_in;
            logic [QW-1:0]  lo_in;
            logic [QW-1:0]  q_in;
            logic [DRW-1:0] n_rem;
            logic [QW-1:0]  n_q;

            if (j == 0) begin : g_head
                assign rem_in = r_pr_rem[i];
                assign lo_in  = r_pr_lo[i];
                assign q_in   = '0;
            end else begin : g_tail
                assign rem_in = r_dv_rem[i][j-1];
                assign lo_in  = r_dv_lo[i][j-1];
                assign q_in   = r_dv_q[i][j-1];
            end

            always_comb begin
                n_rem = {rem_in[DRW-2:0], lo_in[NFB-j]};
                if (n_rem >= DRW'(len_in)) begin
                    n_rem = n_rem - DRW'(len_in);
                    n_q   = {q_in[QW-2:0], 1'b1};
                end else begin
                    n_q   = {q_in[QW-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                r_dv_q[i][j] <= n_q;
            end

            if (j < QW - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    r_dv_rem[i][j] <= n_rem;
                    r_dv_lo[i][j]  <= lo_in;
                end
            end
        end
    end

    // Saturation and sign of the normal; a degenerate word gives zeros
    logic [QXW-1:0] n_qs [0:2];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_qs[i] = QXW'(r_dv_q[i][QW-1]);
            if (r_neg[i][ST_SAT-1]) begin
                if (n_qs[i] > QXW'(NORM_NEG_MAX)) begin
                    n_qs[i] = QXW'(NORM_NEG_MAX);
                end
            end else if (n_qs[i] > QXW'(NORM_POS_MAX)) begin
                n_qs[i] = QXW'(NORM_POS_MAX);
            end
        end
    end

    // Offset: rounded magnitude, saturated, sign restored
    logic [DTW-1:0] n_dm;
    logic [RXW-1:0] n_rr;
    always_comb begin
        n_dm = r_d[DTW-1] ? DTW'(-r_d) : DTW'(r_d);
        n_rr = (RXW'(n_dm) + (RXW'(1) << (NFB - 1))) >> NFB;
        if (r_d[DTW-1]) begin
            if (n_rr > RXW'(OFFS_NEG_MAX)) begin
                n_rr = RXW'(OFFS_NEG_MAX);
            end
        end else if (n_rr > RXW'(OFFS_POS_MAX)) begin
            n_rr = RXW'(OFFS_POS_MAX);
        end
    end

    // Back end: normal, dot product with the first point, offset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (r_deg[ST_SAT-1]) begin
                r_n[i][ST_SAT] <= '0;
            end else if (r_neg[i][ST_SAT-1]) begin
                r_n[i][ST_SAT] <= NORM_W'(QXW'(0) - n_qs[i]);
            end else begin
                r_n[i][ST_SAT] <= NORM_W'(n_qs[i]);
            end
            for (int k = ST_SAT + 1; k <= LAT; k++) begin
                r_n[i][k] <= r_n[i][k-1];
            end
            r_dot[i] <= DPW'(r_n[i][ST_SAT]) * DPW'(r_p1[i][ST_SAT]);
        end
        r_d   <= -(DTW'(r_dot[0]) + DTW'(r_dot[1]) + DTW'(r_dot[2]));
        r_off <= r_d[DTW-1] ? OFFS_W'(RXW'(0) - n_rr) : OFFS_W'(n_rr);
    end

    // Result ports
    assign busy           = 1'b0;
    assign o_valid        = r_vld[LAT];
    assign o_normal_x     = r_n[0][LAT];
    assign o_normal_y     = r_n[1][LAT];
    assign o_normal_z     = r_n[2][LAT];
    assign o_plane_offset = r_off;
    assign o_degenerate   = r_deg[LAT];

endmodule

FILE: hdl/pfp_checker.sv
// Port-level checks for the plane-from-three-points pipeline, bound to the top level.
// Depends on pfp_pkg and plane_from_three_points.
module pfp_checker
    import pfp_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_valid,
    input logic signed [NORM_W-1:0] o_normal_x,
    input logic signed [NORM_W-1:0] o_normal_y,
    input logic signed [NORM_W-1:0] o_normal_z,
    input logic signed [OFFS_W-1:0] o_plane_offset,
    input logic                     o_degenerate
);

    localparam int LAT = pfp_latency(NORMAL_FRAC_BITS);

    // Every accepted word leaves after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_valid)
        else $error("accepted word did not produce a result on time");

    // No result without a word accepted the latency earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching accepted word");

    // Degenerate results carry zeros
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_normal_x == 0 && o_normal_y == 0
                                    && o_normal_z == 0 && o_plane_offset == 0)
        else $error("degenerate result with non-zero fields");

    // A proper plane always has a non-zero normal
    a_normal_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |-> o_normal_x != 0 || o_normal_y != 0 || o_normal_z != 0)
        else $error("non-degenerate result with a zero normal");

endmodule

bind plane_from_three_points pfp_checker #(
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_pfp_checker (.*);

FILE: sim/tb.sv
// Testbench for plane_from_three_points: drives point triples, predicts each plane
// in integer arithmetic and checks every result word. Depends on pfp_pkg and the RTL.
module tb
    import pfp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW  = 16;
    localparam int NFB = 14;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic signed [CW-1:0] c [9];
    } t_points;

    typedef struct {
        logic signed [NORM_W-1:0] nx, ny, nz;
        logic signed [OFFS_W-1:0] offs;
        logic                     degen;
    } t_plane;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] pin [9] = '{default: '0};
    logic o_valid, o_degenerate;
    logic signed [NORM_W-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic signed [OFFS_W-1:0] o_plane_offset;

    t_points pending_words [$];
    t_plane  expected_planes [$];
    int      errors = 0;
    int      idle_cycles = 0;
    bit      stimulus_done = 1'b0;
    bit      hold_sender = 1'b0;
    int      gap = 0;

    always #5 i_clk = ~i_clk;

    plane_from_three_points #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(NFB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_p1_x(pin[0]), .i_p1_y(pin[1]), .i_p1_z(pin[2]),
        .i_p2_x(pin[3]), .i_p2_y(pin[4]), .i_p2_z(pin[5]),
        .i_p3_x(pin[6]), .i_p3_y(pin[7]), .i_p3_z(pin[8]),
        .o_valid(o_valid), .o_normal_x(o_normal_x), .o_normal_y(o_normal_y),
        .o_normal_z(o_normal_z), .o_plane_offset(o_plane_offset),
        .o_degenerate(o_degenerate)
    );

    function automatic int bits_needed(input logic [63:0] m);
        int n;
        n = 0;
        while (m != 0) begin
            n++;
            m = m >> 1;
        end
        return n;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Plane through the three points, with zeros and the flag for a zero cross product.
    function automatic t_plane plane_of(input t_points w);
        longint      u [3], v [3], cr [3], nrm [3], dot, d;
        logic [63:0] m [3], mx, s, len, q, dm, r;
        int          bl;
        t_plane      pl;
        for (int i = 0; i < 3; i++) begin
            u[i] = longint'(w.c[3+i]) - longint'(w.c[i]);
            v[i] = longint'(w.c[6+i]) - longint'(w.c[i]);
        end
        cr[0] = u[1] * v[2] - u[2] * v[1];
        cr[1] = u[2] * v[0] - u[0] * v[2];
        cr[2] = u[0] * v[1] - u[1] * v[0];
        pl = '{default: '0};
        if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
            pl.degen = 1'b1;
            return pl;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = cr[i] < 0 ? -cr[i] : cr[i];
            if (m[i] > mx) mx = m[i];
        end
        bl = bits_needed(mx);
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = bl > 31 ? m[i] >> (bl - 31) : m[i] << (31 - bl);
            s += m[i] * m[i];
        end
        len = floor_sqrt(s);
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << NFB) + (len >> 1)) / len;
            if (cr[i] < 0) begin
                if (q > NORM_NEG_MAX) q = NORM_NEG_MAX;
                nrm[i] = -longint'(q);
            end else begin
                if (q > NORM_POS_MAX) q = NORM_POS_MAX;
                nrm[i] = longint'(q);
            end
            dot += nrm[i] * longint'(w.c[i]);
        end
        d = -dot;
        dm = d < 0 ? -d : d;
        r = (dm + (64'd1 << (NFB - 1))) >> NFB;
        if (d < 0) begin
            if (r > OFFS_NEG_MAX) r = OFFS_NEG_MAX;
            pl.offs = OFFS_W'(-longint'(r));
        end else begin
            if (r > OFFS_POS_MAX) r = OFFS_POS_MAX;
            pl.offs = OFFS_W'(longint'(r));
        end
        pl.nx = NORM_W'(nrm[0]);
        pl.ny = NORM_W'(nrm[1]);
        pl.nz = NORM_W'(nrm[2]);
        return pl;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return CW'($urandom_range(0, 1023)) - 16'd512;
            default: return CW'($urandom());
        endcase
    endfunction

    // Driver: presents one word at a time from the pending queue, with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_sender) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (gap > 0) begin
            gap <= gap - 1;
            start <= 1'b0;
        end else if (pending_words.size() > 0) begin
            t_points w;
            w = pending_words.pop_front();
            for (int i = 0; i < 9; i++) pin[i] <= w.c[i];
            expected_planes.push_back(plane_of(w));
            start <= 1'b1;
            gap <= pick_gap();
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: checks each result word against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_planes.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                t_plane e;
                e = expected_planes.pop_front();
                if (o_normal_x !== e.nx) report_mismatch("normal_x", o_normal_x, e.nx);
                if (o_normal_y !== e.ny) report_mismatch("normal_y", o_normal_y, e.ny);
                if (o_normal_z !== e.nz) report_mismatch("normal_z", o_normal_z, e.nz);
                if (o_plane_offset !== e.offs)
                    report_mismatch("plane_offset", o_plane_offset, e.offs);
                if (o_degenerate !== e.degen)
                    report_mismatch("degenerate", o_degenerate, e.degen);
            end
        end
    end

    // Watchdog: counts cycles in which no word moves in either direction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_points(input logic [CW-1:0] a [9]);
        t_points w;
        for (int i = 0; i < 9; i++) w.c[i] = a[i];
        pending_words.push_back(w);
    endtask

    task automatic add_random(input int count);
        logic [CW-1:0] a [9];
        logic signed [CW-1:0] k;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 9; i++) a[i] = rand_coord();
            // Some collinear triples: p3 repeats p1 or p2, or lies on a scaled edge.
            case ($urandom_range(0, 9))
                0: for (int i = 0; i < 3; i++) a[6+i] = a[i];
                1: for (int i = 0; i < 3; i++) a[6+i] = a[3+i];
                2: begin
                    k = CW'($urandom_range(0, 3));
                    for (int i = 0; i < 3; i++) begin
                        a[3+i] = a[i] + CW'($urandom_range(0, 200)) - 16'd100;
                        a[6+i] = a[i] + k * (a[3+i] - a[i]);
                    end
                end
                default: ;
            endcase
            add_points(a);
        end
    endtask

    initial begin
        logic [CW-1:0] a [9];
        // Directed words: unit axes, extremes, coincident and collinear points.
        a = '{0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 0};             add_points(a);
        a = '{16'h0100, 16'h0100, 16'h0100, 16'h0200, 16'h0100, 16'h0100,
              16'h0100, 16'h0100, 16'h0200};                         add_points(a);
        a = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
              16'h7fff, 16'h8000, 16'h7fff};                         add_points(a);
        a = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
              16'h8000, 16'h7fff, 16'h8000};                         add_points(a);
        a = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
              16'h8000, 16'h8000, 16'h7fff};                         add_points(a);
        a = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
              16'h7fff, 16'h7fff, 16'h8000};                         add_points(a);
        a = '{16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234,
              16'h1234, 16'h1234, 16'h1234};                         add_points(a);
        a = '{0, 0, 0, 16'h0100, 16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'h0200};
        add_points(a);
        a = '{16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 1, 1, 1};       add_points(a);
        a = '{0, 0, 0, 1, 0, 0, 0, 0, 1};                            add_points(a);
        a = '{16'h7fff, 0, 0, 16'h7fff, 1, 0, 16'h7fff, 0, 1};       add_points(a);
        a = '{0, 16'h8000, 0, 1, 16'h8000, 0, 0, 16'h8000, 1};       add_points(a);
        a = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7ffe, 16'h7fff,
              16'h7ffe, 16'h7fff, 16'h7fff};                         add_points(a);
        add_random(450);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Hold the sender off once the first half is in, until every result is back.
        wait (pending_words.size() == 0 && !start);
        @(negedge i_clk);
        hold_sender = 1'b1;
        wait (expected_planes.size() == 0);
        add_random(450);
        @(negedge i_clk);
        hold_sender = 1'b0;

        wait (pending_words.size() == 0 && !start);
        wait (expected_planes.size() == 0);
        repeat (pfp_latency(NFB) + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
